>>> hw/rtl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB status LED sequencer package
// Shared types and constants: mode codes, register indexes, payload and
// state structures.
// ----------------------------------------------------------------------------
package rsl_pkg;

	typedef enum logic [2:0] {
		MODE_OFF        = 3'd0,
		MODE_BOOT       = 3'd1,
		MODE_OPTIMIZING = 3'd2,
		MODE_SLIDESHOW  = 3'd3,
		MODE_TRANSITION = 3'd4,
		MODE_SETTINGS   = 3'd5,
		MODE_ERROR      = 3'd6,
		MODE_SCREENSHOT = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_LED_ENABLE    = 3'd0,
		REG_BRIGHTNESS    = 3'd1,
		REG_SLOW_BLINK_MS = 3'd2,
		REG_FAST_BLINK_MS = 3'd3,
		REG_PULSE_MS      = 3'd4
	} reg_index_t;

	localparam int unsigned CfgDataWidth = 16;

	localparam logic [7:0]  DutyDark         = 8'd255;
	localparam logic [7:0]  BrightnessReset  = 8'd255;
	localparam logic [15:0] SlowBlinkReset   = 16'd500;
	localparam logic [15:0] FastBlinkReset   = 16'd200;
	localparam logic [15:0] PulseReset       = 16'd1000;

	typedef struct packed {
		logic        cmd;
		logic [31:0] now_ms;
		logic [2:0]  new_mode;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_duty;
		logic [7:0] green_duty;
		logic [7:0] blue_duty;
		logic [2:0] mode_now;
	} out_item_t;

	typedef struct packed {
		logic        led_enable;
		logic [7:0]  brightness;
		logic [15:0] slow_blink_ms;
		logic [15:0] fast_blink_ms;
		logic [15:0] pulse_ms;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] mode_start_ms;
		logic [31:0] last_toggle_ms;
		logic        blink_on;
		logic        timers_ready;
	} seq_state_t;

endpackage

>>> hw/rtl/rsl_cfg_regs.sv
// ----------------------------------------------------------------------------
// RGB status LED sequencer configuration registers
// Plain write port into the five control registers; unknown indexes are
// ignored.
// ----------------------------------------------------------------------------
module rsl_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [rsl_pkg::CfgDataWidth-1:0] cfg_data,
	output rsl_pkg::cfg_t                    cfg
);

	rsl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_enable    <= 1'b1;
			cfg_q.brightness    <= rsl_pkg::BrightnessReset;
			cfg_q.slow_blink_ms <= rsl_pkg::SlowBlinkReset;
			cfg_q.fast_blink_ms <= rsl_pkg::FastBlinkReset;
			cfg_q.pulse_ms      <= rsl_pkg::PulseReset;
		end else if (cfg_we) begin
			case (cfg_index)
				rsl_pkg::REG_LED_ENABLE:    cfg_q.led_enable    <= cfg_data[0];
				rsl_pkg::REG_BRIGHTNESS:    cfg_q.brightness    <= cfg_data[7:0];
				rsl_pkg::REG_SLOW_BLINK_MS: cfg_q.slow_blink_ms <= cfg_data[15:0];
				rsl_pkg::REG_FAST_BLINK_MS: cfg_q.fast_blink_ms <= cfg_data[15:0];
				rsl_pkg::REG_PULSE_MS:      cfg_q.pulse_ms      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/rsl_step.sv
// ----------------------------------------------------------------------------
// RGB status LED sequencer step logic
// Combinational next state and result for one item held in the input stage.
// ----------------------------------------------------------------------------
module rsl_step (
	input  rsl_pkg::in_item_t   item,
	input  rsl_pkg::cfg_t       cfg,
	input  rsl_pkg::seq_state_t state,
	output rsl_pkg::seq_state_t state_next,
	output logic                has_result,
	output rsl_pkg::out_item_t  result
);

	rsl_pkg::seq_state_t eff;
	logic        r_lit;
	logic        g_lit;
	logic        b_lit;
	logic [31:0] toggle_age;
	logic [31:0] pulse_age;
	logic [7:0]  lit_duty;

	assign lit_duty = rsl_pkg::DutyDark - cfg.brightness;

	always_comb begin
		// On the first tick after reset or a mode change both timestamps start now.
		eff = state;
		if (!state.timers_ready) begin
			eff.mode_start_ms  = item.now_ms;
			eff.last_toggle_ms = item.now_ms;
			eff.blink_on       = 1'b1;
			eff.timers_ready   = 1'b1;
		end
		toggle_age = item.now_ms - eff.last_toggle_ms;
		pulse_age  = item.now_ms - eff.mode_start_ms;

		state_next = state;
		has_result = 1'b0;
		r_lit      = 1'b0;
		g_lit      = 1'b0;
		b_lit      = 1'b0;
		result.red_duty   = rsl_pkg::DutyDark;
		result.green_duty = rsl_pkg::DutyDark;
		result.blue_duty  = rsl_pkg::DutyDark;
		result.mode_now   = state.mode;

		if (item.cmd) begin
			if (item.new_mode != state.mode) begin
				state_next.mode           = rsl_pkg::mode_t'(item.new_mode);
				state_next.mode_start_ms  = '0;
				state_next.last_toggle_ms = '0;
				state_next.blink_on       = 1'b1;
				state_next.timers_ready   = 1'b0;
			end
		end else if (!cfg.led_enable) begin
			has_result = 1'b1;
		end else begin
			has_result = 1'b1;
			state_next = eff;
			case (state.mode)
				rsl_pkg::MODE_BOOT: begin
					if (toggle_age >= {16'd0, cfg.slow_blink_ms}) begin
						state_next.blink_on       = !eff.blink_on;
						state_next.last_toggle_ms = item.now_ms;
					end
					r_lit = state_next.blink_on;
					g_lit = state_next.blink_on;
				end
				rsl_pkg::MODE_OPTIMIZING: begin
					if (toggle_age >= {16'd0, cfg.fast_blink_ms}) begin
						state_next.blink_on       = !eff.blink_on;
						state_next.last_toggle_ms = item.now_ms;
					end
					b_lit = state_next.blink_on;
				end
				rsl_pkg::MODE_SLIDESHOW: begin
					g_lit = 1'b1;
				end
				rsl_pkg::MODE_TRANSITION, rsl_pkg::MODE_SCREENSHOT: begin
					if (pulse_age >= {16'd0, cfg.pulse_ms}) begin
						state_next.mode          = rsl_pkg::MODE_SLIDESHOW;
						state_next.mode_start_ms = item.now_ms;
						g_lit = 1'b1;
					end else begin
						r_lit = (state.mode == rsl_pkg::MODE_TRANSITION);
						g_lit = 1'b1;
						b_lit = 1'b1;
					end
				end
				rsl_pkg::MODE_SETTINGS: begin
					r_lit = 1'b1;
					b_lit = 1'b1;
				end
				rsl_pkg::MODE_ERROR: begin
					r_lit = 1'b1;
				end
				default: ;
			endcase
			result.red_duty   = r_lit ? lit_duty : rsl_pkg::DutyDark;
			result.green_duty = g_lit ? lit_duty : rsl_pkg::DutyDark;
			result.blue_duty  = b_lit ? lit_duty : rsl_pkg::DutyDark;
			result.mode_now   = state_next.mode;
		end
	end

endmodule

>>> hw/rtl/rgb_status_led_sequencer_top.sv
// ----------------------------------------------------------------------------
// RGB status LED sequencer, top level
// Input stage, sequencer state, step logic and output register.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the in channel (valid/ready). An item is either a tick that
// carries the millisecond time or a mode request. Every tick yields one result
// on the out channel with the three active-low duties and the current mode;
// a mode request yields none.
// An accepted tick passes from the input stage through the step logic into
// the output register that drives the out channel. Throughput: one item per
// cycle while out_ready is high. The figure is set by the single pass of the
// step logic (one 32-bit subtract and compare) between the input stage and
// the output register, which also carries the sequencer state update.
// When the receiver stalls, the held result stays in the output register and
// one more tick waits in the input stage; in_ready then drops.
// Reset puts the sequencer in boot mode with timers uninitialized and loads
// the register defaults (enabled, full brightness, 500/200/1000 ms).
// Configuration writes on cfg_we take effect at the next edge.
// ----------------------------------------------------------------------------
module rgb_status_led_sequencer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rsl_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rsl_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_index,
	input  logic [rsl_pkg::CfgDataWidth-1:0] cfg_data
);

	rsl_pkg::cfg_t       cfg;
	rsl_pkg::in_item_t   item_s1;
	logic                valid_s1;
	rsl_pkg::seq_state_t state_q;
	rsl_pkg::seq_state_t state_next;
	logic                has_result;
	rsl_pkg::out_item_t  result;
	rsl_pkg::out_item_t  out_q;
	logic                out_valid_q;
	logic                out_free;
	logic                adv_s1;

	rsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rsl_step u_step (
		.item       (item_s1),
		.cfg        (cfg),
		.state      (state_q),
		.state_next (state_next),
		.has_result (has_result),
		.result     (result)
	);

	// A mode request leaves the input stage without needing the output slot.
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (item_s1.cmd || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= rsl_pkg::MODE_BOOT;
			state_q.mode_start_ms  <= '0;
			state_q.last_toggle_ms <= '0;
			state_q.blink_on       <= 1'b0;
			state_q.timers_ready   <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && has_result) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// A mode request must never fill the output register.
	a_cmd_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.cmd) |=> (out_valid_q == $past(out_valid_q && !out_ready)))
		else $error("mode request produced a result");

	// Sequencer state only moves when an item leaves the input stage.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv_s1) |-> $stable(state_q))
		else $error("sequencer state changed without a transfer");

	// Timers are only marked uninitialized by a mode request.
	a_timers_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q.timers_ready) |-> $past(adv_s1 && item_s1.cmd))
		else $error("timers cleared without a mode request");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB status LED sequencer testbench
// Sends ticks and mode requests through the valid/ready input channel and
// checks each result against a table expectation or a cycle-free LED model.
// A short table covers each mode, the blink and pulse timing edges, time
// wrap, the disabled state and zero intervals. Random phases with their own
// register settings follow. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_MODE = 1'b1;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned PHASES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 88;

	typedef struct {
		logic                cmd_is_cfg_unused_dummy;
	} unused_t;

	typedef struct {
		logic                is_cfg;
		rsl_pkg::reg_index_t idx;
		logic [15:0]         val;
		rsl_pkg::in_item_t   item;
		logic                typed;
		rsl_pkg::out_item_t  want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rsl_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	rsl_pkg::out_item_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [rsl_pkg::CfgDataWidth-1:0] cfg_data;

	// Model state of the sequencer and its register file.
	rsl_pkg::cfg_t led_cfg;
	rsl_pkg::mode_t led_mode;
	logic [31:0] led_start;
	logic [31:0] led_toggle;
	logic led_blink;
	logic led_ready;

	rsl_pkg::out_item_t duty_q[$];
	plan_row_t plan_q[$];
	logic [31:0] clock_ms;
	logic quiet;
	int unsigned fail_cnt;
	int unsigned checked_cnt;
	int unsigned tick_cnt;
	int unsigned req_cnt;
	int unsigned write_cnt;

	always #10 clk = ~clk;

	rgb_status_led_sequencer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic rsl_pkg::out_item_t leds(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input rsl_pkg::mode_t m);
		rsl_pkg::out_item_t o;
		o.red_duty = r;
		o.green_duty = g;
		o.blue_duty = b;
		o.mode_now = m;
		return o;
	endfunction

	function automatic logic [7:0] lit_duty(input logic lit);
		return lit ? rsl_pkg::DutyDark - led_cfg.brightness : rsl_pkg::DutyDark;
	endfunction

	// Advances the model by one item; a tick yields the expected LED result.
	task automatic predict_led(input rsl_pkg::in_item_t it, output logic has_res,
			output rsl_pkg::out_item_t res);
		logic r;
		logic g;
		logic b;
		logic [31:0] interval;
		r = 1'b0;
		g = 1'b0;
		b = 1'b0;
		has_res = 1'b0;
		res = '0;
		if (it.cmd == CMD_MODE) begin
			if (rsl_pkg::mode_t'(it.new_mode) != led_mode) begin
				led_mode = rsl_pkg::mode_t'(it.new_mode);
				led_start = '0;
				led_toggle = '0;
				led_blink = 1'b1;
				led_ready = 1'b0;
			end
		end else begin
			has_res = 1'b1;
			if (!led_cfg.led_enable) begin
				res = leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::DutyDark, led_mode);
			end else begin
				if (!led_ready) begin
					led_start = it.now_ms;
					led_toggle = it.now_ms;
					led_blink = 1'b1;
					led_ready = 1'b1;
				end
				case (led_mode)
					rsl_pkg::MODE_BOOT, rsl_pkg::MODE_OPTIMIZING: begin
						interval = (led_mode == rsl_pkg::MODE_BOOT)
							? 32'(led_cfg.slow_blink_ms)
							: 32'(led_cfg.fast_blink_ms);
						if (it.now_ms - led_toggle >= interval) begin
							led_blink = !led_blink;
							led_toggle = it.now_ms;
						end
						r = led_blink && (led_mode == rsl_pkg::MODE_BOOT);
						g = r;
						b = led_blink && (led_mode == rsl_pkg::MODE_OPTIMIZING);
					end
					rsl_pkg::MODE_SLIDESHOW: g = 1'b1;
					rsl_pkg::MODE_TRANSITION, rsl_pkg::MODE_SCREENSHOT: begin
						// The tick that ends the pulse already shows slideshow green.
						if (it.now_ms - led_start >= 32'(led_cfg.pulse_ms)) begin
							led_mode = rsl_pkg::MODE_SLIDESHOW;
							led_start = it.now_ms;
							g = 1'b1;
						end else begin
							r = (led_mode == rsl_pkg::MODE_TRANSITION);
							g = 1'b1;
							b = 1'b1;
						end
					end
					rsl_pkg::MODE_SETTINGS: begin
						r = 1'b1;
						b = 1'b1;
					end
					rsl_pkg::MODE_ERROR: r = 1'b1;
					default: ;
				endcase
				res = leds(lit_duty(r), lit_duty(g), lit_duty(b), led_mode);
			end
		end
	endtask

	function automatic plan_row_t blank_row();
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx = rsl_pkg::REG_LED_ENABLE;
		row.val = '0;
		row.item = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic void add_tick(input logic [31:0] now, input logic typed,
			input rsl_pkg::out_item_t want);
		plan_row_t row;
		row = blank_row();
		row.item.cmd = CMD_TICK;
		row.item.now_ms = now;
		row.typed = typed;
		row.want = want;
		plan_q.push_back(row);
	endfunction

	function automatic void add_mode(input rsl_pkg::mode_t m);
		plan_row_t row;
		row = blank_row();
		row.item.cmd = CMD_MODE;
		row.item.new_mode = m;
		plan_q.push_back(row);
	endfunction

	function automatic void add_cfg(input rsl_pkg::reg_index_t idx, input logic [15:0] val);
		plan_row_t row;
		row = blank_row();
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		plan_q.push_back(row);
	endfunction

	function automatic logic [15:0] pick_ms();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k == 0) return 16'd0;
		if (k == 1) return 16'd1;
		if (k == 2) return 16'hFFFF;
		if (k < 6) return 16'($urandom_range(1, 65535));
		return 16'($urandom_range(1, 40));
	endfunction

	// Holds valid until the transfer happens, then updates the model.
	task automatic send_item(input rsl_pkg::in_item_t it, input logic typed,
			input rsl_pkg::out_item_t want);
		logic has_res;
		rsl_pkg::out_item_t res;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_led(it, has_res, res);
		if (has_res) duty_q.push_back(typed ? want : res);
		if (it.cmd == CMD_MODE) req_cnt++;
		else tick_cnt++;
	endtask

	task automatic sender_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 7)) @(posedge clk);
	endtask

	// Waits until every result is back and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		while (duty_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input rsl_pkg::reg_index_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rsl_pkg::REG_LED_ENABLE:    led_cfg.led_enable = val[0];
			rsl_pkg::REG_BRIGHTNESS:    led_cfg.brightness = val[7:0];
			rsl_pkg::REG_SLOW_BLINK_MS: led_cfg.slow_blink_ms = val;
			rsl_pkg::REG_FAST_BLINK_MS: led_cfg.fast_blink_ms = val;
			rsl_pkg::REG_PULSE_MS:      led_cfg.pulse_ms = val;
			default: ;
		endcase
		write_cnt++;
		@(posedge clk);
	endtask

	task automatic next_item(output rsl_pkg::in_item_t it);
		int unsigned k;
		k = $urandom_range(0, 99);
		it.new_mode = 3'($urandom_range(0, 7));
		if (k < 15) begin
			it.cmd = CMD_MODE;
			it.now_ms = $urandom;
		end else begin
			it.cmd = CMD_TICK;
			if (k < 85) clock_ms = clock_ms + $urandom_range(0, 20);
			else if (k < 97) clock_ms = clock_ms + $urandom_range(0, 2000);
			else clock_ms = $urandom;
			it.now_ms = clock_ms;
		end
	endtask

	// Receiver: random stall bursts, none in the final phase.
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsl_pkg::out_item_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (duty_q.size() == 0) begin
				$error("Result transfer with nothing expected: %p", out_data);
				fail_cnt++;
			end else begin
				exp_res = duty_q.pop_front();
				checked_cnt++;
				if (out_data.red_duty !== exp_res.red_duty) begin
					$error("red_duty mismatch: expected %0d, got %0d",
						exp_res.red_duty, out_data.red_duty);
					fail_cnt++;
				end
				if (out_data.green_duty !== exp_res.green_duty) begin
					$error("green_duty mismatch: expected %0d, got %0d",
						exp_res.green_duty, out_data.green_duty);
					fail_cnt++;
				end
				if (out_data.blue_duty !== exp_res.blue_duty) begin
					$error("blue_duty mismatch: expected %0d, got %0d",
						exp_res.blue_duty, out_data.blue_duty);
					fail_cnt++;
				end
				if (out_data.mode_now !== exp_res.mode_now) begin
					$error("mode_now mismatch: expected %0d, got %0d",
						exp_res.mode_now, out_data.mode_now);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		#(64'd20_000_000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		rsl_pkg::in_item_t it;
		logic [15:0] slow_v;
		logic [15:0] fast_v;
		logic [15:0] pulse_v;
		logic [7:0] bright_v;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		quiet = 1'b0;
		fail_cnt = 0;
		checked_cnt = 0;
		tick_cnt = 0;
		req_cnt = 0;
		write_cnt = 0;
		clock_ms = '0;
		led_cfg.led_enable = 1'b1;
		led_cfg.brightness = rsl_pkg::BrightnessReset;
		led_cfg.slow_blink_ms = rsl_pkg::SlowBlinkReset;
		led_cfg.fast_blink_ms = rsl_pkg::FastBlinkReset;
		led_cfg.pulse_ms = rsl_pkg::PulseReset;
		led_mode = rsl_pkg::MODE_BOOT;
		led_start = '0;
		led_toggle = '0;
		led_blink = 1'b0;
		led_ready = 1'b0;

		// Boot blink from reset: lit until the slow interval has passed.
		add_tick(32'd0, 1'b1,
			leds(8'd0, 8'd0, rsl_pkg::DutyDark, rsl_pkg::MODE_BOOT));
		add_tick(32'd499, 1'b1,
			leds(8'd0, 8'd0, rsl_pkg::DutyDark, rsl_pkg::MODE_BOOT));
		add_tick(32'd500, 1'b1,
			leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::DutyDark,
				rsl_pkg::MODE_BOOT));
		add_mode(rsl_pkg::MODE_BOOT);
		// Optimizing blink across the 32-bit time wrap.
		add_mode(rsl_pkg::MODE_OPTIMIZING);
		add_tick(32'hFFFF_FFFF, 1'b1,
			leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, 8'd0, rsl_pkg::MODE_OPTIMIZING));
		add_tick(32'd199, 1'b1,
			leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::DutyDark,
				rsl_pkg::MODE_OPTIMIZING));
		add_mode(rsl_pkg::MODE_TRANSITION);
		add_tick(32'd1000, 1'b1, leds(8'd0, 8'd0, 8'd0, rsl_pkg::MODE_TRANSITION));
		add_tick(32'd2000, 1'b1,
			leds(rsl_pkg::DutyDark, 8'd0, rsl_pkg::DutyDark, rsl_pkg::MODE_SLIDESHOW));
		add_mode(rsl_pkg::MODE_SCREENSHOT);
		add_tick(32'd5, 1'b1,
			leds(rsl_pkg::DutyDark, 8'd0, 8'd0, rsl_pkg::MODE_SCREENSHOT));
		add_tick(32'd1005, 1'b1,
			leds(rsl_pkg::DutyDark, 8'd0, rsl_pkg::DutyDark, rsl_pkg::MODE_SLIDESHOW));
		add_mode(rsl_pkg::MODE_SETTINGS);
		add_tick(32'd7, 1'b1,
			leds(8'd0, rsl_pkg::DutyDark, 8'd0, rsl_pkg::MODE_SETTINGS));
		add_mode(rsl_pkg::MODE_ERROR);
		add_tick(32'd8, 1'b1,
			leds(8'd0, rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::MODE_ERROR));
		add_mode(rsl_pkg::MODE_OFF);
		add_tick(32'd9, 1'b1,
			leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::DutyDark,
				rsl_pkg::MODE_OFF));
		// Zero brightness leaves lit channels dark.
		add_cfg(rsl_pkg::REG_BRIGHTNESS, 16'd0);
		add_mode(rsl_pkg::MODE_SLIDESHOW);
		add_tick(32'd10, 1'b1,
			leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::DutyDark,
				rsl_pkg::MODE_SLIDESHOW));
		// Disabled: mode requests still land, ticks show dark.
		add_cfg(rsl_pkg::REG_BRIGHTNESS, 16'd100);
		add_cfg(rsl_pkg::REG_LED_ENABLE, 16'd0);
		add_mode(rsl_pkg::MODE_ERROR);
		add_tick(32'd12, 1'b1,
			leds(rsl_pkg::DutyDark, rsl_pkg::DutyDark, rsl_pkg::DutyDark,
				rsl_pkg::MODE_ERROR));
		// Zero intervals: blink toggles on every tick, pulse ends at once.
		add_cfg(rsl_pkg::REG_LED_ENABLE, 16'd1);
		add_cfg(rsl_pkg::REG_SLOW_BLINK_MS, 16'd0);
		add_cfg(rsl_pkg::REG_PULSE_MS, 16'd0);
		add_mode(rsl_pkg::MODE_BOOT);
		add_tick(32'd13, 1'b0, '0);
		add_tick(32'd13, 1'b0, '0);
		add_mode(rsl_pkg::MODE_TRANSITION);
		add_tick(32'd14, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg) begin
				settle();
				write_reg(plan_q[i].idx, plan_q[i].val);
			end else begin
				send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
				if ($urandom_range(0, 4) == 0) sender_gap();
			end
		end

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			settle();
			// Phase 1 runs everything at full scale, phase 2 at zero brightness and 1 ms intervals.
			if (phase == 1) begin
				bright_v = 8'd255;
				slow_v = 16'hFFFF;
				fast_v = 16'hFFFF;
				pulse_v = 16'hFFFF;
			end else if (phase == 2) begin
				bright_v = 8'd0;
				slow_v = 16'd1;
				fast_v = 16'd1;
				pulse_v = 16'd1;
			end else begin
				bright_v = 8'($urandom_range(0, 255));
				slow_v = pick_ms();
				fast_v = pick_ms();
				pulse_v = pick_ms();
			end
			write_reg(rsl_pkg::REG_LED_ENABLE, (phase == 3) ? 16'd0 : 16'd1);
			write_reg(rsl_pkg::REG_BRIGHTNESS, 16'(bright_v));
			write_reg(rsl_pkg::REG_SLOW_BLINK_MS, slow_v);
			write_reg(rsl_pkg::REG_FAST_BLINK_MS, fast_v);
			write_reg(rsl_pkg::REG_PULSE_MS, pulse_v);
			if (phase == 5) clock_ms = 32'hFFFF_FF00;
			quiet = (phase == PHASES - 1);
			for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Sender holds off once until the block has nothing in flight.
				if (phase == 4 && n == ITEMS_PER_PHASE / 2) settle();
				next_item(it);
				send_item(it, 1'b0, '0);
				if (!quiet && $urandom_range(0, 4) == 0) sender_gap();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Summary: %0d ticks and %0d mode requests sent, %0d results checked.",
			tick_cnt, req_cnt, checked_cnt);
		$display("Summary: %0d register writes over %0d settings, incl. disabled and zero.",
			write_cnt, PHASES + 1);
		if (fail_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
